[sv/bats_pkg.sv]
// Shared constants, state encoding and controller/datapath interface types
// for the box-average thumbnail scaler. No dependencies.
package bats_pkg;

    localparam int SRC_W     = 256;  // source frame width in pixels
    localparam int SRC_H     = 192;  // source frame height in pixels
    localparam int CH_W      = 5;    // bits per color channel
    localparam int PIX_W     = 16;   // packed RGB555 pixel width
    localparam int NUM_CH    = 3;
    localparam int DEF_OUT_W = 64;
    localparam int DEF_OUT_H = 48;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic take;      // accept the input pixel
        logic merge;     // fold the box sum into the column store
        logic out_load;  // load the quotient into the output register
    } t_cmd;

    typedef struct packed {
        logic col_end;   // the offered pixel closes a box column
        logic band_end;  // the pending box also closes its band of rows
        logic div_done;  // divider is in its final step
        logic out_free;  // output register can take a new result
    } t_stat;

endpackage

[sv/bats_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/bats_div.sv]
// Restoring divider for three channel sums sharing one divisor, one quotient
// bit per cycle. Depends on bats_pkg.
module bats_div #(
    parameter int SUM_W = 21,
    parameter int CNT_W = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_start,
    input  logic [bats_pkg::NUM_CH-1:0][SUM_W-1:0]          i_num,
    input  logic [CNT_W-1:0]                                i_den,
    output logic                                            o_done,
    output logic [bats_pkg::NUM_CH-1:0][bats_pkg::CH_W-1:0] o_quo
);

    localparam int QW   = bats_pkg::CH_W;
    localparam int DW   = (SUM_W > CNT_W + QW - 1) ? SUM_W : CNT_W + QW - 1;
    localparam int STW  = $clog2(QW);
    localparam int LAST = QW - 1;

    logic                                 r_busy;
    logic [STW-1:0]                       r_step;
    logic [bats_pkg::NUM_CH-1:0][DW-1:0]  r_rem;
    logic [DW-1:0]                        r_den;
    logic [bats_pkg::NUM_CH-1:0][QW-1:0]  r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STW'(1);
            if (r_step == STW'(LAST)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The quotient never exceeds the channel maximum, so the divisor starts
    // shifted up by one less than the channel width.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < bats_pkg::NUM_CH; k++) begin
                r_rem[k] <= DW'(i_num[k]);
            end
            r_den <= DW'(i_den) << LAST;
        end else if (r_busy) begin
            for (int k = 0; k < bats_pkg::NUM_CH; k++) begin
                if (r_rem[k] >= r_den) begin
                    r_rem[k] <= r_rem[k] - r_den;
                    r_quo[k] <= {r_quo[k][QW-2:0], 1'b1};
                end else begin
                    r_quo[k] <= {r_quo[k][QW-2:0], 1'b0};
                end
            end
            r_den <= r_den >> 1;
        end
    end

    assign o_done = r_busy && (r_step == STW'(LAST));
    assign o_quo  = r_quo;

endmodule

[sv/bats_dp.sv]
// Datapath: position counters, box edge trackers, run sums, column sum RAM,
// divider and output register. Depends on bats_pkg, bats_ram, bats_div.
module bats_dp #(
    parameter int OUT_W = bats_pkg::DEF_OUT_W,
    parameter int OUT_H = bats_pkg::DEF_OUT_H
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bats_pkg::PIX_W-1:0] i_pixel,
    input  logic                       i_frame_start,
    input  bats_pkg::t_cmd             i_cmd,
    output bats_pkg::t_stat            o_stat,
    output logic [bats_pkg::PIX_W-1:0] o_thumb_pixel,
    output logic                       o_thumb_last,
    output logic                       o_out_valid,
    input  logic                       i_out_ready
);

    localparam int NCH       = bats_pkg::NUM_CH;
    localparam int CH_W      = bats_pkg::CH_W;
    localparam int SRC_W     = bats_pkg::SRC_W;
    localparam int SRC_H     = bats_pkg::SRC_H;
    localparam int BOX_W_MAX = (SRC_W + OUT_W - 1) / OUT_W;
    localparam int BOX_H_MAX = (SRC_H + OUT_H - 1) / OUT_H;
    localparam int CNT_MAX   = BOX_W_MAX * BOX_H_MAX;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int SUM_W     = $clog2(((1 << CH_W) - 1) * CNT_MAX + 1);
    localparam int AW        = (OUT_W > 1) ? $clog2(OUT_W) : 1;
    localparam int RW        = (OUT_H > 1) ? $clog2(OUT_H) : 1;
    localparam int SC_W      = $clog2(SRC_W);
    localparam int SR_W      = $clog2(SRC_H);
    localparam int CE_W      = $clog2(SRC_W + 1);
    localparam int RE_W      = $clog2(SRC_H + 1);
    localparam int Q_C       = SRC_W / OUT_W;
    localparam int R_C       = SRC_W % OUT_W;
    localparam int Q_R       = SRC_H / OUT_H;
    localparam int R_R       = SRC_H % OUT_H;

    typedef logic [NCH-1:0][SUM_W-1:0] t_sums;

    // Position counters and incremental box edges.
    logic [SC_W-1:0] r_scol, n_scol, e_scol;
    logic [SR_W-1:0] r_srow, n_srow, e_srow;
    logic [AW-1:0]   r_tcol, n_tcol, e_tcol;
    logic [RW-1:0]   r_trow, n_trow, e_trow;
    logic [CE_W-1:0] r_cbeg, n_cbeg, e_cbeg;
    logic [CE_W-1:0] r_cend, n_cend, e_cend;
    logic [CE_W-1:0] r_crem, n_crem, e_crem;
    logic [RE_W-1:0] r_rbeg, n_rbeg, e_rbeg;
    logic [RE_W-1:0] r_rend, n_rend, e_rend;
    logic [RE_W-1:0] r_rrem, n_rrem, e_rrem;
    t_sums           r_run, n_run, e_run, run_new;

    // Box captured at a column edge, waiting to be merged.
    t_sums           r_box;
    logic [AW-1:0]   r_widx;
    logic            r_first;
    logic            r_bend;
    logic            r_last;
    logic [CE_W-1:0] r_bw;
    logic [RE_W-1:0] r_bh;

    logic [bats_pkg::PIX_W-1:0] r_opix;
    logic                       r_olast;
    logic                       r_ovalid;

    logic [NCH-1:0][CH_W-1:0]   px_ch;
    logic                       col_hit, row_first, row_hit, last_hit;
    logic [CE_W:0]              c_sum;
    logic [RE_W:0]              rw_sum;
    logic [CE_W-1:0]            c_step_end, c_step_rem;
    logic [RE_W-1:0]            r_step_end, r_step_rem;
    logic [NCH*SUM_W-1:0]       rd_data;
    t_sums                      rd_sums, total;
    logic [CE_W+RE_W-1:0]       box_cnt;
    logic                       div_done;
    logic [NCH-1:0][CH_W-1:0]   quo;

    // A frame start restarts every counter before the pixel is counted.
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            px_ch[k] = i_pixel[k*CH_W +: CH_W];
        end
        e_scol = i_frame_start ? '0 : r_scol;
        e_srow = i_frame_start ? '0 : r_srow;
        e_tcol = i_frame_start ? '0 : r_tcol;
        e_trow = i_frame_start ? '0 : r_trow;
        e_cbeg = i_frame_start ? '0 : r_cbeg;
        e_cend = i_frame_start ? CE_W'(Q_C) : r_cend;
        e_crem = i_frame_start ? CE_W'(R_C) : r_crem;
        e_rbeg = i_frame_start ? '0 : r_rbeg;
        e_rend = i_frame_start ? RE_W'(Q_R) : r_rend;
        e_rrem = i_frame_start ? RE_W'(R_R) : r_rrem;
        e_run  = i_frame_start ? '0 : r_run;
        for (int k = 0; k < NCH; k++) begin
            run_new[k] = e_run[k] + SUM_W'(px_ch[k]);
        end
        col_hit   = (CE_W'(e_scol) + CE_W'(1)) == e_cend;
        row_first = (RE_W + 1)'(e_srow) == (RE_W + 1)'(e_rbeg);
        row_hit   = ((RE_W + 1)'(e_srow) + (RE_W + 1)'(1)) == (RE_W + 1)'(e_rend);
        last_hit  = (int'(e_trow) == OUT_H - 1) && (int'(e_tcol) == OUT_W - 1);

        // Next edge = previous edge + quotient, carrying the remainder.
        c_sum      = (CE_W + 1)'(e_crem) + (CE_W + 1)'(R_C);
        c_step_rem = (c_sum >= (CE_W + 1)'(OUT_W)) ?
                     CE_W'(c_sum - (CE_W + 1)'(OUT_W)) : CE_W'(c_sum);
        c_step_end = e_cend + CE_W'(Q_C) + CE_W'(c_sum >= (CE_W + 1)'(OUT_W));
        rw_sum     = (RE_W + 1)'(e_rrem) + (RE_W + 1)'(R_R);
        r_step_rem = (rw_sum >= (RE_W + 1)'(OUT_H)) ?
                     RE_W'(rw_sum - (RE_W + 1)'(OUT_H)) : RE_W'(rw_sum);
        r_step_end = e_rend + RE_W'(Q_R) + RE_W'(rw_sum >= (RE_W + 1)'(OUT_H));
    end

    always_comb begin
        n_scol = r_scol;
        n_srow = r_srow;
        n_tcol = r_tcol;
        n_trow = r_trow;
        n_cbeg = r_cbeg;
        n_cend = r_cend;
        n_crem = r_crem;
        n_rbeg = r_rbeg;
        n_rend = r_rend;
        n_rrem = r_rrem;
        n_run  = r_run;
        if (i_cmd.take) begin
            n_scol = e_scol + SC_W'(1);
            n_srow = e_srow;
            n_tcol = e_tcol;
            n_trow = e_trow;
            n_cbeg = e_cbeg;
            n_cend = e_cend;
            n_crem = e_crem;
            n_rbeg = e_rbeg;
            n_rend = e_rend;
            n_rrem = e_rrem;
            n_run  = col_hit ? '0 : run_new;
            if (col_hit) begin
                n_tcol = e_tcol + AW'(1);
                n_cbeg = e_cend;
                n_cend = c_step_end;
                n_crem = c_step_rem;
            end
            if (e_scol == SC_W'(SRC_W - 1)) begin
                n_scol = '0;
                n_tcol = '0;
                n_cbeg = '0;
                n_cend = CE_W'(Q_C);
                n_crem = CE_W'(R_C);
                n_srow = e_srow + SR_W'(1);
                if (row_hit) begin
                    n_trow = e_trow + RW'(1);
                    n_rbeg = e_rend;
                    n_rend = r_step_end;
                    n_rrem = r_step_rem;
                end
                if (e_srow == SR_W'(SRC_H - 1)) begin
                    n_srow = '0;
                    n_trow = '0;
                    n_rbeg = '0;
                    n_rend = RE_W'(Q_R);
                    n_rrem = RE_W'(R_R);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol   <= '0;
            r_srow   <= '0;
            r_tcol   <= '0;
            r_trow   <= '0;
            r_cbeg   <= '0;
            r_cend   <= CE_W'(Q_C);
            r_crem   <= CE_W'(R_C);
            r_rbeg   <= '0;
            r_rend   <= RE_W'(Q_R);
            r_rrem   <= RE_W'(R_R);
            r_run    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_scol <= n_scol;
            r_srow <= n_srow;
            r_tcol <= n_tcol;
            r_trow <= n_trow;
            r_cbeg <= n_cbeg;
            r_cend <= n_cend;
            r_crem <= n_crem;
            r_rbeg <= n_rbeg;
            r_rend <= n_rend;
            r_rrem <= n_rrem;
            r_run  <= n_run;
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && col_hit) begin
            r_box   <= run_new;
            r_widx  <= e_tcol;
            r_first <= row_first;
            r_bend  <= row_hit;
            r_last  <= last_hit;
            r_bw    <= e_cend - e_cbeg;
            r_bh    <= e_rend - e_rbeg;
        end
        if (i_cmd.out_load) begin
            r_opix  <= {1'b1, quo[2], quo[1], quo[0]};
            r_olast <= r_last;
        end
    end

    // The column entry is read on every transfer; it is used only after a
    // column edge, in the merge cycle that follows.
    bats_ram #(
        .WIDTH (NCH * SUM_W),
        .DEPTH (OUT_W)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.merge),
        .i_wr_addr (r_widx),
        .i_wr_data (total),
        .i_rd_en   (i_cmd.take),
        .i_rd_addr (e_tcol),
        .o_rd_data (rd_data)
    );

    always_comb begin
        rd_sums = rd_data;
        for (int k = 0; k < NCH; k++) begin
            total[k] = r_first ? r_box[k] : rd_sums[k] + r_box[k];
        end
        box_cnt = (CE_W + RE_W)'(r_bw) * (CE_W + RE_W)'(r_bh);
    end

    bats_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.merge && r_bend),
        .i_num   (total),
        .i_den   (CNT_W'(box_cnt)),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign o_stat.col_end  = col_hit;
    assign o_stat.band_end = r_bend;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    assign o_thumb_pixel = r_opix;
    assign o_thumb_last  = r_olast;
    assign o_out_valid   = r_ovalid;

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_merge_after_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> $past(i_cmd.take && col_hit))
        else $error("merge without a preceding column edge");

    a_thumb_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_trow) < OUT_H) && (int'(r_tcol) < OUT_W))
        else $error("thumbnail position out of range");

endmodule

[sv/bats_ctrl.sv]
// Controller state machine: sequences pixel transfer, column merge, division
// and result load. Depends on bats_pkg.
module bats_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bats_pkg::t_stat i_stat,
    output bats_pkg::t_cmd  o_cmd
);

    bats_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bats_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bats_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.col_end) begin
                        n_state = bats_pkg::S_MERGE;
                    end
                end
            end
            bats_pkg::S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state = i_stat.band_end ? bats_pkg::S_DIV : bats_pkg::S_IDLE;
            end
            bats_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = bats_pkg::S_EMIT;
                end
            end
            bats_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = bats_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bats_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/box_average_thumbnail_scaler.sv]
// A pixel inside a box column keeps the controller idle, so such
// pixels transfer back to back. A pixel that closes a box column also takes
// a merge state (column sum RAM read at the transfer, then merge and write).
// A pixel that closes a thumbnail box takes merge, the restoring divider, then
// the result load, which waits until the output register is free.
// Reset: counters return to the frame origin; the column sum RAM is not cleared.
module box_average_thumbnail_scaler #(
    parameter int OUT_W = bats_pkg::DEF_OUT_W,
    parameter int OUT_H = bats_pkg::DEF_OUT_H
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bats_pkg::PIX_W-1:0] i_pixel,
    input  logic                       i_frame_start,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [bats_pkg::PIX_W-1:0] o_thumb_pixel,
    output logic                       o_thumb_last
);

    bats_pkg::t_cmd  cmd;
    bats_pkg::t_stat stat;

    bats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bats_dp #(
        .OUT_W (OUT_W),
        .OUT_H (OUT_H)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_thumb_pixel (o_thumb_pixel),
        .o_thumb_last  (o_thumb_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready)
    );

endmodule
